// ===== hw/rtl/m7fn_pkg.sv =====
`timescale 1ns / 1ps

package m7fn_pkg;

  // Name layout: base part, then extension, then a trailing NUL.
  localparam int BASE_CHARS = 8;
  localparam int NAME_CHARS = 11;

  localparam int POS_W = $clog2(NAME_CHARS + 1);
  localparam int IDX_W = $clog2(NAME_CHARS + 2);

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_ACK   = 8'h06;
  localparam logic [7:0] CH_NAK   = 8'h15;
  localparam logic [7:0] CH_SUB   = 8'h1A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_U     = 8'h75;

  localparam logic [7:0] SUM_INIT = 8'((32'(CH_SUB) + NAME_CHARS * 32'(CH_SPACE)) % 256);

  localparam logic [7:0] RETRY_RESET = 8'd6;

  localparam logic [1:0] OC_RUN  = 2'd0;
  localparam logic [1:0] OC_OK   = 2'd1;
  localparam logic [1:0] OC_FAIL = 2'd2;

  localparam logic [2:0] MODE_CHAR    = 3'd0;
  localparam logic [2:0] MODE_START   = 3'd1;
  localparam logic [2:0] MODE_RX      = 3'd2;
  localparam logic [2:0] MODE_TIMEOUT = 3'd3;
  localparam logic [2:0] MODE_LINEERR = 3'd4;

  typedef enum logic [1:0] {
    LINK_IDLE,
    LINK_WAITNAK,
    LINK_WAITACK,
    LINK_WAITCHECK
  } link_phase_t;

  typedef enum logic [1:0] {
    FILL_BASE,
    FILL_EXT,
    FILL_DONE
  } fill_phase_t;

  typedef struct packed {
    logic [2:0] mode;
    logic [7:0] value;
    logic       first_char;
  } in_item_t;

  typedef struct packed {
    logic       has_byte;
    logic [7:0] tx_byte;
    logic [1:0] outcome;
    logic       last_of_run;
  } out_item_t;

  typedef struct packed {
    logic       en;
    logic       first;
    logic [7:0] ch;
  } load_req_t;

  typedef struct packed {
    logic [1:0] cnt;
    out_item_t  r0;
    out_item_t  r1;
  } push_req_t;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

endpackage

// ===== hw/rtl/m7fn_name_buf.sv =====
`timescale 1ns / 1ps

module m7fn_name_buf
  import m7fn_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  load_req_t        load,
  input  logic [IDX_W-1:0] rd_idx,
  output logic [7:0]       rd_byte,
  output logic [7:0]       first_byte,
  output logic [7:0]       name_sum
);

  logic [7:0]       store_r [NAME_CHARS];
  logic [7:0]       store_nxt [NAME_CHARS];
  logic [POS_W-1:0] pos_r, pos_nxt;
  fill_phase_t      phase_r, phase_nxt;
  logic [7:0]       sum_r, sum_nxt;

  logic [POS_W-1:0] pos_eff;
  fill_phase_t      phase_eff;
  logic [7:0]       sum_eff;
  logic             do_put;
  logic [7:0]       uc;

  always_comb begin
    pos_eff   = load.first ? '0 : pos_r;
    phase_eff = load.first ? FILL_BASE : phase_r;
    sum_eff   = load.first ? SUM_INIT : sum_r;

    uc = load.ch;
    if (load.ch >= 8'h61 && load.ch <= 8'h7A) begin
      uc = load.ch - 8'h20;
    end

    do_put    = 1'b0;
    phase_nxt = phase_eff;
    if (phase_eff != FILL_DONE) begin
      if (load.ch == CH_NUL) begin
        phase_nxt = FILL_DONE;
      end else if (phase_eff == FILL_BASE) begin
        if (load.ch == CH_DOT) begin
          phase_nxt = FILL_EXT;
        end else if (pos_eff < POS_W'(BASE_CHARS)) begin
          do_put = 1'b1;
        end else begin
          phase_nxt = FILL_EXT;
          do_put    = (pos_eff < POS_W'(NAME_CHARS));
        end
      end else begin
        do_put = (pos_eff < POS_W'(NAME_CHARS));
      end
    end

    // A slot that is written always still holds a space, since the fill
    // position only moves forward after a clear.
    pos_nxt = do_put ? pos_eff + 1'b1 : pos_eff;
    sum_nxt = do_put ? sum_eff - CH_SPACE + uc : sum_eff;

    for (int i = 0; i < NAME_CHARS; i++) begin
      if (do_put && pos_eff == POS_W'(i)) begin
        store_nxt[i] = uc;
      end else if (load.first) begin
        store_nxt[i] = CH_SPACE;
      end else begin
        store_nxt[i] = store_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      phase_r <= FILL_BASE;
      sum_r   <= SUM_INIT;
      for (int i = 0; i < NAME_CHARS; i++) begin
        store_r[i] <= CH_SPACE;
      end
    end else if (load.en) begin
      pos_r   <= pos_nxt;
      phase_r <= phase_nxt;
      sum_r   <= sum_nxt;
      for (int i = 0; i < NAME_CHARS; i++) begin
        store_r[i] <= store_nxt[i];
      end
    end
  end

  // The slot past the name is the trailing NUL.
  always_comb begin
    rd_byte = CH_NUL;
    for (int i = 0; i < NAME_CHARS; i++) begin
      if (rd_idx == IDX_W'(i)) begin
        rd_byte = store_r[i];
      end
    end
  end

  assign first_byte = store_r[0];
  assign name_sum   = sum_r;

endmodule

// ===== hw/rtl/m7fn_out_queue.sv =====
`timescale 1ns / 1ps

module m7fn_out_queue
  import m7fn_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  push_req_t push,
  output logic      full,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  out_item_t         slot_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic [QPTR_W-1:0] wr_ptr_p1;
  logic              pop;

  // Room for a two-result beat must always be there when an item is taken.
  assign full      = (cnt_r > QCNT_W'(QDEPTH - 2));
  assign out_valid = (cnt_r != '0);
  assign out_data  = slot_r[rd_ptr_r];
  assign pop       = out_valid && !out_stall;
  assign wr_ptr_p1 = wr_ptr_r + 1'b1;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + QPTR_W'(push.cnt);
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + QCNT_W'(push.cnt) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      slot_r[wr_ptr_r] <= push.r0;
    end
    if (push.cnt == 2'd2) begin
      slot_r[wr_ptr_p1] <= push.r1;
    end
  end

endmodule

// ===== hw/rtl/modem7_filename_sender_core.sv =====
`timescale 1ns / 1ps

// Sender side of the MODEM7 filename exchange.
// The in_ channel carries line events and filename characters as one beat
// each (in_valid / in_stall). Name characters are packed into an 8.3 field
// while the link is idle; a start beat then sends ACK and the name bytes,
// and each received byte, timeout or line error advances the exchange.
// Each accepted beat yields zero, one or two result beats on the out_
// channel, the last of them flagged by last_of_run.
// The results of a beat are registered into the result queue and offered
// in order behind any results still waiting there. One input beat is taken
// per cycle while in_stall is low.
// Results wait in a four-entry queue; in_stall rises when fewer than two
// slots are free, so a stalled receiver holds off the input side only once
// that queue fills. cfg_ writes set retry_limit and are always ready.
// Synchronous reset returns the link to idle, clears the name to spaces,
// empties the result queue and sets retry_limit to 6.
module modem7_filename_sender_core
  import m7fn_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_item_t   in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output out_item_t  out_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data
);

  logic             accept;
  logic             q_full;
  link_phase_t      phase_r, phase_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [7:0]       tries_r, tries_nxt;
  logic [7:0]       limit_r;
  load_req_t        load;
  push_req_t        push;
  logic [7:0]       rd_byte;
  logic [7:0]       first_byte;
  logic [7:0]       name_sum;
  logic             got;
  logic             nak_fail;
  logic [1:0]       nak_oc;
  logic [7:0]       tries_inc;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;
  assign accept    = in_valid && !q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= RETRY_RESET;
    end else if (cfg_valid && cfg_ready) begin
      limit_r <= cfg_data;
    end
  end

  assign load.en    = accept && (in_data.mode == MODE_CHAR) && (phase_r == LINK_IDLE);
  assign load.first = in_data.first_char;
  assign load.ch    = in_data.value;

  m7fn_name_buf u_name_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (load),
    .rd_idx     (idx_r),
    .rd_byte    (rd_byte),
    .first_byte (first_byte),
    .name_sum   (name_sum)
  );

  assign got       = (in_data.mode == MODE_RX);
  assign nak_fail  = (tries_r > limit_r);
  assign nak_oc    = nak_fail ? OC_FAIL : OC_RUN;
  assign tries_inc = (tries_r != 8'hFF) ? tries_r + 8'd1 : tries_r;

  always_comb begin
    phase_nxt = phase_r;
    idx_nxt   = idx_r;
    tries_nxt = tries_r;
    push.cnt  = 2'd0;
    push.r0   = '{has_byte: 1'b0, tx_byte: 8'h00, outcome: OC_RUN, last_of_run: 1'b1};
    push.r1   = '{has_byte: 1'b1, tx_byte: first_byte, outcome: OC_RUN, last_of_run: 1'b1};

    if (accept) begin
      case (in_data.mode)
        MODE_START: begin
          tries_nxt = 8'd0;
          push.cnt  = 2'd2;
          push.r0   = '{has_byte: 1'b1, tx_byte: CH_ACK, outcome: OC_RUN, last_of_run: 1'b0};
          idx_nxt   = IDX_W'(1);
          phase_nxt = LINK_WAITACK;
        end
        MODE_LINEERR: begin
          if (phase_r != LINK_IDLE) begin
            phase_nxt = LINK_IDLE;
            push.cnt  = 2'd1;
            push.r0   = '{has_byte: 1'b0, tx_byte: 8'h00, outcome: OC_FAIL, last_of_run: 1'b1};
          end
        end
        MODE_RX, MODE_TIMEOUT: begin
          if (phase_r == LINK_WAITNAK && got && in_data.value == CH_NAK) begin
            push.cnt  = 2'd2;
            push.r0   = '{has_byte: 1'b1, tx_byte: CH_ACK, outcome: OC_RUN, last_of_run: 1'b0};
            idx_nxt   = IDX_W'(1);
            phase_nxt = LINK_WAITACK;
          end else if (phase_r == LINK_WAITACK && got && in_data.value == CH_ACK) begin
            push.cnt = 2'd1;
            if (idx_r <= IDX_W'(NAME_CHARS)) begin
              push.r0 = '{has_byte: 1'b1, tx_byte: rd_byte, outcome: OC_RUN, last_of_run: 1'b1};
              idx_nxt = idx_r + 1'b1;
            end else begin
              push.r0   = '{has_byte: 1'b1, tx_byte: CH_SUB, outcome: OC_RUN, last_of_run: 1'b1};
              phase_nxt = LINK_WAITCHECK;
            end
          end else if (phase_r == LINK_WAITCHECK && got && in_data.value == name_sum) begin
            push.cnt  = 2'd1;
            push.r0   = '{has_byte: 1'b1, tx_byte: CH_ACK, outcome: OC_OK, last_of_run: 1'b1};
            phase_nxt = LINK_IDLE;
          end else if (phase_r != LINK_IDLE) begin
            // Every fall back into the NAK wait counts as one try.
            if (nak_fail) begin
              phase_nxt = LINK_IDLE;
            end else begin
              tries_nxt = tries_inc;
              phase_nxt = LINK_WAITNAK;
            end
            if (phase_r == LINK_WAITNAK && !got) begin
              push.cnt = nak_fail ? 2'd1 : 2'd0;
              push.r0  = '{has_byte: 1'b0, tx_byte: 8'h00, outcome: nak_oc, last_of_run: 1'b1};
            end else begin
              push.cnt = 2'd1;
              push.r0  = '{has_byte: 1'b1, tx_byte: CH_U, outcome: nak_oc, last_of_run: 1'b1};
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= LINK_IDLE;
      idx_r   <= '0;
      tries_r <= '0;
    end else begin
      phase_r <= phase_nxt;
      idx_r   <= idx_nxt;
      tries_r <= tries_nxt;
    end
  end

  m7fn_out_queue u_out_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (q_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ===== tb/tb_modem7_filename_sender_core.sv =====
`timescale 1ns / 1ps

module tb_modem7_filename_sender_core;
  import m7fn_pkg::*;

  localparam logic [7:0] LOWER_A = 8'h61;
  localparam logic [7:0] LOWER_Z = 8'h7A;
  localparam logic [7:0] UPPER_A = 8'h41;
  localparam logic [7:0] UPPER_Z = 8'h5A;
  localparam logic [7:0] DIGIT_0 = 8'h30;
  localparam logic [7:0] DIGIT_9 = 8'h39;
  localparam logic [7:0] CASE_GAP = 8'h20;
  localparam logic [7:0] RETRY_MAX = 8'hFF;
  localparam logic [7:0] RETRY_NONE = 8'h00;
  localparam logic [2:0] MODE_SPARE = 3'd5;
  localparam logic [2:0] MODE_SPARE_B = 3'd6;
  localparam logic [2:0] MODE_SPARE_C = 3'd7;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES = 200;
  localparam int PHASE_BEATS = 150;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [7:0] cfg_data = '0;

  modem7_filename_sender_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow of the sender's state, advanced once per accepted input beat.
  int          retry_lim;
  link_phase_t lk;
  logic [7:0]  name_mem [16];
  int          fill_pos;
  fill_phase_t fill_ph;
  int          send_idx;
  int          tries;
  logic [7:0]  name_sum;

  out_item_t expected_beats[$];
  out_item_t step_beats[$];
  out_item_t want_beat;

  int errors = 0;
  int beats_sent = 0;
  int burst_left = 0;

  bit hold_req = 1'b0;
  int hold_left = 0;
  int stall_left = 0;
  int run_left = 0;
  int stall_roll;

  function automatic void clear_name();
    for (int i = 0; i < 16; i++) name_mem[i] = (i < NAME_CHARS) ? CH_SPACE : CH_NUL;
    fill_pos = 0;
    fill_ph = FILL_BASE;
    name_sum = SUM_INIT;
  endfunction

  function automatic void store_char(logic [7:0] c);
    logic [7:0] u;
    u = (c >= LOWER_A && c <= LOWER_Z) ? 8'(c - CASE_GAP) : c;
    name_sum = 8'(name_sum - name_mem[fill_pos] + u);
    name_mem[fill_pos] = u;
    fill_pos = fill_pos + 1;
  endfunction

  function automatic void load_name_char(logic [7:0] c);
    if (fill_ph == FILL_DONE) return;
    if (c == CH_NUL) begin
      fill_ph = FILL_DONE;
      return;
    end
    if (fill_ph == FILL_BASE) begin
      if (c == CH_DOT) begin
        fill_ph = FILL_EXT;
        return;
      end
      if (fill_pos < BASE_CHARS) begin
        store_char(c);
        return;
      end
      // A ninth non-dot character spills straight into the extension.
      fill_ph = FILL_EXT;
    end
    if (fill_pos < NAME_CHARS) store_char(c);
  endfunction

  function automatic void emit(logic has, logic [7:0] b, logic [1:0] oc);
    out_item_t r;
    r.has_byte = has;
    r.tx_byte = has ? b : CH_NUL;
    r.outcome = oc;
    r.last_of_run = 1'b0;
    step_beats.push_back(r);
  endfunction

  // Every entry into the NAK wait costs one try; too many ends the transfer.
  function automatic logic [1:0] enter_nak_wait();
    if (tries > retry_lim) begin
      lk = LINK_IDLE;
      return OC_FAIL;
    end
    if (tries < 255) tries++;
    lk = LINK_WAITNAK;
    return OC_RUN;
  endfunction

  function automatic void begin_send();
    emit(1'b1, CH_ACK, OC_RUN);
    emit(1'b1, name_mem[0], OC_RUN);
    send_idx = 1;
    lk = LINK_WAITACK;
  endfunction

  function automatic void advance_link(in_item_t it);
    logic [1:0] oc;
    logic got;
    out_item_t tail;
    step_beats.delete();
    got = (it.mode == MODE_RX);
    case (it.mode)
      MODE_CHAR: begin
        if (lk == LINK_IDLE) begin
          if (it.first_char) clear_name();
          load_name_char(it.value);
        end
      end
      MODE_START: begin
        tries = 0;
        begin_send();
      end
      MODE_LINEERR: begin
        if (lk != LINK_IDLE) begin
          lk = LINK_IDLE;
          emit(1'b0, CH_NUL, OC_FAIL);
        end
      end
      MODE_RX, MODE_TIMEOUT: begin
        if (lk == LINK_WAITNAK) begin
          if (got && it.value == CH_NAK) begin
            begin_send();
          end else if (!got) begin
            oc = enter_nak_wait();
            if (oc != OC_RUN) emit(1'b0, CH_NUL, oc);
          end else begin
            oc = enter_nak_wait();
            emit(1'b1, CH_U, oc);
          end
        end else if (lk == LINK_WAITACK && got && it.value == CH_ACK) begin
          if (send_idx <= NAME_CHARS) begin
            emit(1'b1, name_mem[send_idx], OC_RUN);
            send_idx++;
          end else begin
            emit(1'b1, CH_SUB, OC_RUN);
            lk = LINK_WAITCHECK;
          end
        end else if (lk == LINK_WAITCHECK && got && it.value == name_sum) begin
          emit(1'b1, CH_ACK, OC_OK);
          lk = LINK_IDLE;
        end else if (lk != LINK_IDLE) begin
          oc = enter_nak_wait();
          emit(1'b1, CH_U, oc);
        end
      end
      default: ;
    endcase
    if (step_beats.size() > 0) begin
      tail = step_beats.pop_back();
      tail.last_of_run = 1'b1;
      step_beats.push_back(tail);
    end
    foreach (step_beats[i]) expected_beats.push_back(step_beats[i]);
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("[%0t] mismatch on %s: got 0x%0h, want 0x%0h", $time, field, got, want);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_beats.size() == 0) begin
        report_mismatch("unexpected result beat", 32'(out_data), 32'd0);
      end else begin
        want_beat = expected_beats.pop_front();
        if (out_data.has_byte !== want_beat.has_byte)
          report_mismatch("has_byte", 32'(out_data.has_byte), 32'(want_beat.has_byte));
        if (out_data.tx_byte !== want_beat.tx_byte)
          report_mismatch("tx_byte", 32'(out_data.tx_byte), 32'(want_beat.tx_byte));
        if (out_data.outcome !== want_beat.outcome)
          report_mismatch("outcome", 32'(out_data.outcome), 32'(want_beat.outcome));
        if (out_data.last_of_run !== want_beat.last_of_run)
          report_mismatch("last_of_run", 32'(out_data.last_of_run),
                          32'(want_beat.last_of_run));
      end
    end
  end

  // Receiver: short random stalls, occasional long ones, quiet stretches, and
  // a long hold-off on request.
  always @(posedge clk) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left <= HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if (run_left > 0) begin
      run_left <= run_left - 1;
      out_stall <= 1'b0;
    end else begin
      stall_roll = $urandom_range(0, 99);
      if (stall_roll < 50) begin
        run_left <= $urandom_range(0, 3);
        out_stall <= 1'b0;
      end else if (stall_roll < 85) begin
        stall_left <= $urandom_range(0, 2);
        out_stall <= 1'b1;
      end else if (stall_roll < 95) begin
        run_left <= $urandom_range(20, 60);
        out_stall <= 1'b0;
      end else begin
        stall_left <= $urandom_range(10, 40);
        out_stall <= 1'b1;
      end
    end
  end

  function automatic in_item_t beat_of(logic [2:0] mode, logic [7:0] value, logic first);
    in_item_t it;
    it.mode = mode;
    it.value = value;
    it.first_char = first;
    return it;
  endfunction

  function automatic int pick_gap();
    int r;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      burst_left = $urandom_range(20, 50);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_beat(in_item_t it, bit paced);
    int gap;
    gap = paced ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    advance_link(it);
    beats_sent++;
  endtask

  task automatic await_results();
    in_valid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_retry_limit(logic [7:0] v);
    await_results();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    retry_lim = v;
  endtask

  function automatic logic [7:0] pick_name_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 8'($urandom_range(LOWER_A, LOWER_Z));
    if (r < 55) return 8'($urandom_range(UPPER_A, UPPER_Z));
    if (r < 65) return 8'($urandom_range(DIGIT_0, DIGIT_9));
    if (r < 77) return CH_DOT;
    if (r < 81) return CH_NUL;
    return 8'($urandom_range(0, 255));
  endfunction

  // Mostly the reply the sender is waiting for, sometimes a disturbance.
  function automatic in_item_t pick_reply();
    int r;
    r = $urandom_range(0, 99);
    if (r < 1) return beat_of(MODE_LINEERR, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    if (r < 2) return beat_of(MODE_START, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    if (r < 4) return beat_of(MODE_TIMEOUT, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    if (r < 6) return beat_of(MODE_RX, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    if (r < 7) return beat_of(MODE_CHAR, pick_name_char(), 1'($urandom_range(0, 1)));
    case (lk)
      LINK_WAITNAK: return beat_of(MODE_RX, CH_NAK, 1'b0);
      LINK_WAITCHECK: return beat_of(MODE_RX, name_sum, 1'b0);
      default: return beat_of(MODE_RX, CH_ACK, 1'b0);
    endcase
  endfunction

  task automatic load_random_name();
    int len;
    logic first;
    len = $urandom_range(0, 14);
    for (int i = 0; i < len; i++) begin
      first = (i == 0) ? 1'b1 : ($urandom_range(0, 19) == 0);
      send_beat(beat_of(MODE_CHAR, pick_name_char(), first), 1'b1);
    end
  endtask

  task automatic test_directed_events();
    // Lowercase, first dot, NUL end and a character dropped after it.
    send_beat(beat_of(MODE_CHAR, 8'h61, 1'b1), 1'b1);
    send_beat(beat_of(MODE_CHAR, 8'h42, 1'b0), 1'b1);
    send_beat(beat_of(MODE_CHAR, CH_DOT, 1'b0), 1'b1);
    send_beat(beat_of(MODE_CHAR, 8'h7A, 1'b0), 1'b1);
    send_beat(beat_of(MODE_CHAR, CH_NUL, 1'b0), 1'b1);
    send_beat(beat_of(MODE_CHAR, 8'hFF, 1'b0), 1'b1);
    // Unused modes and line events while idle do nothing.
    send_beat(beat_of(MODE_SPARE, 8'hFF, 1'b1), 1'b1);
    send_beat(beat_of(MODE_SPARE_B, 8'h00, 1'b0), 1'b1);
    send_beat(beat_of(MODE_SPARE_C, 8'hFF, 1'b1), 1'b1);
    send_beat(beat_of(MODE_RX, 8'hFF, 1'b1), 1'b1);
    send_beat(beat_of(MODE_TIMEOUT, 8'h00, 1'b0), 1'b1);
    send_beat(beat_of(MODE_LINEERR, 8'h00, 1'b0), 1'b1);
    // A transfer with a wrong byte, a timeout in the NAK wait, a NAK restart,
    // a restart by start, a name character while running and a line error.
    send_beat(beat_of(MODE_START, 8'h00, 1'b0), 1'b1);
    send_beat(beat_of(MODE_RX, CH_ACK, 1'b0), 1'b1);
    send_beat(beat_of(MODE_CHAR, 8'h51, 1'b1), 1'b1);
    send_beat(beat_of(MODE_RX, 8'h00, 1'b0), 1'b1);
    send_beat(beat_of(MODE_TIMEOUT, 8'hFF, 1'b1), 1'b1);
    send_beat(beat_of(MODE_RX, CH_NAK, 1'b0), 1'b1);
    send_beat(beat_of(MODE_START, 8'hFF, 1'b1), 1'b1);
    send_beat(beat_of(MODE_LINEERR, 8'hFF, 1'b1), 1'b1);
    await_results();
  endtask

  task automatic test_full_transfer();
    send_beat(beat_of(MODE_START, 8'h00, 1'b0), 1'b1);
    while (lk != LINK_IDLE) send_beat(pick_reply(), 1'b1);
    await_results();
  endtask

  task automatic test_retry_extremes();
    // No retries allowed: the second wrong byte ends the transfer.
    write_retry_limit(RETRY_NONE);
    send_beat(beat_of(MODE_START, 8'h00, 1'b0), 1'b1);
    send_beat(beat_of(MODE_RX, 8'h00, 1'b0), 1'b1);
    send_beat(beat_of(MODE_RX, 8'h00, 1'b0), 1'b1);
    // Largest limit: the try count saturates and never exceeds it.
    write_retry_limit(RETRY_MAX);
    send_beat(beat_of(MODE_START, 8'h00, 1'b0), 1'b1);
    send_beat(beat_of(MODE_RX, 8'hFF, 1'b0), 1'b1);
    repeat (260) send_beat(beat_of(MODE_TIMEOUT, 8'h00, 1'b0), 1'b0);
    send_beat(beat_of(MODE_RX, 8'h00, 1'b0), 1'b1);
    send_beat(beat_of(MODE_LINEERR, 8'h00, 1'b0), 1'b1);
    await_results();
  endtask

  task automatic test_output_backpressure();
    await_results();
    hold_req = 1'b1;
    @(posedge clk);
    @(posedge clk);
    // Back-to-back beats against a held receiver fill the result queue.
    repeat (40) begin
      if (lk == LINK_IDLE) send_beat(beat_of(MODE_START, 8'h00, 1'b0), 1'b0);
      else send_beat(pick_reply(), 1'b0);
    end
    await_results();
  endtask

  task automatic test_random_transfers(int goal);
    int steps;
    while (beats_sent < goal) begin
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 6))
          send_beat(beat_of(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                            1'($urandom_range(0, 1))), 1'b1);
      end else begin
        load_random_name();
        send_beat(beat_of(MODE_START, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1))),
                  1'b1);
        steps = 0;
        while (lk != LINK_IDLE && steps < 80) begin
          send_beat(pick_reply(), 1'b1);
          steps++;
        end
      end
    end
  endtask

  initial begin
    retry_lim = RETRY_RESET;
    lk = LINK_IDLE;
    send_idx = 0;
    tries = 0;
    clear_name();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    test_directed_events();
    test_full_transfer();
    test_retry_extremes();
    test_output_backpressure();

    write_retry_limit(RETRY_RESET);
    test_random_transfers(beats_sent + PHASE_BEATS);
    write_retry_limit(RETRY_NONE);
    test_random_transfers(beats_sent + PHASE_BEATS);
    write_retry_limit(RETRY_MAX);
    test_random_transfers(beats_sent + PHASE_BEATS);
    write_retry_limit(8'($urandom_range(1, 10)));
    test_random_transfers(beats_sent + PHASE_BEATS);
    write_retry_limit(8'd3);
    test_random_transfers(beats_sent + PHASE_BEATS);

    await_results();
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ===== modem7_filename_sender_core.f =====
hw/rtl/m7fn_pkg.sv
hw/rtl/m7fn_name_buf.sv
hw/rtl/m7fn_out_queue.sv
hw/rtl/modem7_filename_sender_core.sv
tb/tb_modem7_filename_sender_core.sv
